### rtl/drm_pkg.sv
// Shared types, codes and constants for the dirty region merger.
package drm_pkg;

  localparam int COORD_W           = 11;
  localparam int FIELD_W           = 16;
  localparam int CLIP_W            = 18;
  localparam int SLOT_W            = 3;
  localparam int TOTAL_W           = 4;
  localparam int STATUS_W          = 3;
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 3;
  localparam int DEF_MAX_REGIONS   = 8;
  localparam logic [COORD_W-1:0] SCREEN_W_RESET = 11'd240;
  localparam logic [COORD_W-1:0] SCREEN_H_RESET = 11'd240;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

  typedef enum logic {
    OP_MARK  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FOLDED   = 3'd2,
    ST_REJECTED = 3'd3,
    ST_DRAINED  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_CHECK,
    S_TEST,
    S_FOLD,
    S_DRD,
    S_DOUT,
    S_EMIT
  } state_t;

endpackage

### rtl/drm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drm_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/drm_box_unit.sv
// Shared touch test and union of a stored region and the candidate rectangle.
module drm_box_unit
  import drm_pkg::*;
(
  input  box_t stored,
  input  box_t cand,
  output logic touch,
  output box_t joined
);

  logic [COORD_W:0] ax2, ay2, bx2, by2;
  logic [COORD_W:0] x2, y2, wx, wy;
  logic [COORD_W-1:0] x1, y1;

  always_comb begin
    ax2 = {1'b0, stored.x} + {1'b0, stored.w};
    ay2 = {1'b0, stored.y} + {1'b0, stored.h};
    bx2 = {1'b0, cand.x} + {1'b0, cand.w};
    by2 = {1'b0, cand.y} + {1'b0, cand.h};
    touch = !((ax2 < {1'b0, cand.x}) || (bx2 < {1'b0, stored.x}) ||
              (ay2 < {1'b0, cand.y}) || (by2 < {1'b0, stored.y}));
    x1 = (stored.x < cand.x) ? stored.x : cand.x;
    y1 = (stored.y < cand.y) ? stored.y : cand.y;
    x2 = (ax2 > bx2) ? ax2 : bx2;
    y2 = (ay2 > by2) ? ay2 : by2;
    wx = x2 - {1'b0, x1};
    wy = y2 - {1'b0, y1};
    joined.x = x1;
    joined.y = y1;
    joined.w = wx[COORD_W-1:0];
    joined.h = wy[COORD_W-1:0];
  end

endmodule

### rtl/dirty_region_merger.sv
// Top level of the dirty region merger: sequencer, clip logic and config port.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   in       | in_valid/in_stall  | opcode, rect_x, rect_y, rect_w, rect_h
//   out      | out_valid/out_stall| status, slot, region_x/y/w/h, region_total, last
//   cfg      | APB psel/penable   | screen_width (0x0), screen_height (0x4)
//
// A mark takes the word, is clipped in S_CLIP and S_CHECK, has each stored region scanned
// through the single RAM read port and box unit, goes on through S_FOLD and a further
// S_TEST on a fold, and is handed off in S_EMIT. A drain takes the word, then per stored
// region a RAM read, capture and hand-off, or a single hand-off when the list is empty.
// Reset is synchronous; it empties the list and restores the 240x240 screen size.
// in_stall is high whenever the sequencer is busy; out_stall only holds the
// output word and the sequencer while a new word waits for the output register.
module dirty_region_merger
  import drm_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic signed [FIELD_W-1:0] rect_x,
  input  logic signed [FIELD_W-1:0] rect_y,
  input  logic signed [FIELD_W-1:0] rect_w,
  input  logic signed [FIELD_W-1:0] rect_h,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [SLOT_W-1:0]         slot,
  output logic [COORD_W-1:0]        region_x,
  output logic [COORD_W-1:0]        region_y,
  output logic [COORD_W-1:0]        region_w,
  output logic [COORD_W-1:0]        region_h,
  output logic [TOTAL_W-1:0]        region_total,
  output logic                      last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic          fold, fold_next;
  logic          op_drain;

  logic [COORD_W-1:0] screen_width, screen_height;

  logic signed [FIELD_W-1:0] rx, ry, rw, rh;
  logic signed [CLIP_W-1:0]  cx, cy, x2, y2;
  logic                      bad;
  box_t                      cand, cand_next;

  status_t            res_status, res_status_next;
  logic [SLOT_W-1:0]  res_slot, res_slot_next;
  box_t               res_box, res_box_next;
  logic [TOTAL_W-1:0] res_total, res_total_next;
  logic               res_last, res_last_next;

  status_t            out_status;
  box_t               out_box;
  logic [SLOT_W-1:0]  out_slot;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;
  logic               out_load, out_free;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  box_t          wr_data, rd_data;
  logic          touch;
  box_t          joined;

  logic                     in_accept, cfg_write;
  logic signed [CLIP_W-1:0] sum_x, sum_y, x2_c, y2_c, cx_c, cy_c, sw_e, sh_e;
  logic signed [CLIP_W-1:0] dx, dy;
  logic                     bad_c, empty;
  box_t                     clip_box, app_box;
  logic [CW-1:0]            idx_inc, count_inc;
  logic [AW+SLOT_W-1:0]     idx_ext, app_ext;
  logic [CW+TOTAL_W-1:0]    count_ext, count_inc_ext;
  logic                     do_append;

  drm_ram #(
    .WIDTH($bits(box_t)),
    .DEPTH(MAX_REGIONS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  drm_box_unit u_box (
    .stored(rd_data),
    .cand  (cand),
    .touch (touch),
    .joined(joined)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = {{(APB_DATA_W-COORD_W){1'b0}},
                      (paddr[2] == REG_SCREEN_HEIGHT) ? screen_height : screen_width};

  assign idx_inc       = CW'(idx) + CW'(1);
  assign count_inc     = count + CW'(1);
  assign idx_ext       = {{SLOT_W{1'b0}}, idx};
  assign app_ext       = {{SLOT_W{1'b0}}, count[AW-1:0]};
  assign count_ext     = {{TOTAL_W{1'b0}}, count};
  assign count_inc_ext = {{TOTAL_W{1'b0}}, count_inc};

  always_comb begin
    sw_e  = signed'({{(CLIP_W-COORD_W){1'b0}}, screen_width});
    sh_e  = signed'({{(CLIP_W-COORD_W){1'b0}}, screen_height});
    sum_x = {{2{rx[FIELD_W-1]}}, rx} + {{2{rw[FIELD_W-1]}}, rw};
    sum_y = {{2{ry[FIELD_W-1]}}, ry} + {{2{rh[FIELD_W-1]}}, rh};
    x2_c  = (sum_x < sw_e) ? sum_x : sw_e;
    y2_c  = (sum_y < sh_e) ? sum_y : sh_e;
    cx_c  = rx[FIELD_W-1] ? '0 : {2'b00, rx};
    cy_c  = ry[FIELD_W-1] ? '0 : {2'b00, ry};
    bad_c = (rw <= 16'sd0) || (rh <= 16'sd0);
    empty = bad || (cx >= x2) || (cy >= y2);
    dx    = x2 - cx;
    dy    = y2 - cy;
    clip_box.x = cx[COORD_W-1:0];
    clip_box.y = cy[COORD_W-1:0];
    clip_box.w = dx[COORD_W-1:0];
    clip_box.h = dy[COORD_W-1:0];
    app_box = (state == S_CHECK) ? clip_box : cand;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    fold_next       = fold;
    cand_next       = cand;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_box_next    = res_box;
    res_total_next  = res_total;
    res_last_next   = res_last;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = joined;
    rd_addr         = '0;
    out_load        = 1'b0;
    do_append       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fold_next = 1'b0;
          idx_next  = '0;
          if (opcode == OP_DRAIN) begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              res_slot_next   = '0;
              res_box_next    = '0;
              res_total_next  = '0;
              res_last_next   = 1'b1;
              state_next      = S_EMIT;
            end else begin
              state_next = S_DRD;
            end
          end else begin
            state_next = S_CLIP;
          end
        end
      end
      S_CLIP: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (empty) begin
          res_status_next = ST_REJECTED;
          res_slot_next   = '0;
          res_box_next    = '0;
          res_total_next  = count_ext[TOTAL_W-1:0];
          res_last_next   = 1'b1;
          state_next      = S_EMIT;
        end else begin
          cand_next = clip_box;
          if (count == '0) begin
            do_append = 1'b1;
          end else begin
            state_next = S_TEST;
          end
        end
      end
      S_TEST: begin
        rd_addr = idx_inc[AW-1:0];
        if (touch || fold) begin
          wr_en           = 1'b1;
          wr_addr         = idx;
          wr_data         = joined;
          res_status_next = fold ? ST_FOLDED : ST_MERGED;
          res_slot_next   = idx_ext[SLOT_W-1:0];
          res_box_next    = joined;
          res_total_next  = count_ext[TOTAL_W-1:0];
          res_last_next   = 1'b1;
          state_next      = S_EMIT;
        end else if (idx_inc == count) begin
          if (count < CW'(MAX_REGIONS)) begin
            do_append = 1'b1;
          end else begin
            fold_next  = 1'b1;
            idx_next   = '0;
            state_next = S_FOLD;
          end
        end else begin
          idx_next = idx_inc[AW-1:0];
        end
      end
      S_FOLD: begin
        state_next = S_TEST;
      end
      S_DRD: begin
        rd_addr    = idx;
        state_next = S_DOUT;
      end
      S_DOUT: begin
        res_status_next = ST_DRAINED;
        res_slot_next   = idx_ext[SLOT_W-1:0];
        res_box_next    = rd_data;
        res_total_next  = '0;
        res_last_next   = (idx_inc == count);
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (res_last) begin
            if (op_drain) begin
              count_next = '0;
            end
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc[AW-1:0];
            state_next = S_DRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (do_append) begin
      wr_en           = 1'b1;
      wr_addr         = count[AW-1:0];
      wr_data         = app_box;
      res_status_next = ST_APPENDED;
      res_slot_next   = app_ext[SLOT_W-1:0];
      res_box_next    = app_box;
      res_total_next  = count_inc_ext[TOTAL_W-1:0];
      res_last_next   = 1'b1;
      count_next      = count_inc;
      state_next      = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      fold          <= 1'b0;
      out_valid     <= 1'b0;
      screen_width  <= SCREEN_W_RESET;
      screen_height <= SCREEN_H_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      fold  <= fold_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        if (paddr[2] == REG_SCREEN_HEIGHT) begin
          screen_height <= pwdata[COORD_W-1:0];
        end else begin
          screen_width <= pwdata[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_drain <= (opcode == OP_DRAIN);
      rx       <= rect_x;
      ry       <= rect_y;
      rw       <= rect_w;
      rh       <= rect_h;
    end
    if (state == S_CLIP) begin
      cx  <= cx_c;
      cy  <= cy_c;
      x2  <= x2_c;
      y2  <= y2_c;
      bad <= bad_c;
    end
    cand       <= cand_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_box    <= res_box_next;
    res_total  <= res_total_next;
    res_last   <= res_last_next;
    if (out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_box    <= res_box;
      out_total  <= res_total;
      out_last   <= res_last;
    end
  end

  assign status       = out_status;
  assign slot         = out_slot;
  assign region_x     = out_box.x;
  assign region_y     = out_box.y;
  assign region_w     = out_box.w;
  assign region_h     = out_box.h;
  assign region_total = out_total;
  assign last         = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS))
    else $error("region count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != S_IDLE))
    else $error("sequencer idle right after taking a word");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && res_last && op_drain) |=> (count == '0))
    else $error("list not empty after drain");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CHECK || state == S_TEST))
    else $error("store written outside mark update");
`endif

endmodule

### sim/dirty_region_merger_tb.sv
// Self-checking testbench for the dirty region merger: marks, drains and screen sizes.
module dirty_region_merger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drm_pkg::*;

  localparam int NUM_SLOTS   = DEF_MAX_REGIONS;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    opcode_t                   op;
    logic signed [FIELD_W-1:0] x, y, w, h;
  } rect_item_t;

  typedef struct {
    status_t             st;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  rx, ry, rw, rh;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } region_word_t;

  typedef struct {
    int x, y, w, h;
  } area_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      opcode = 1'b0;
  logic signed [FIELD_W-1:0] rect_x = '0;
  logic signed [FIELD_W-1:0] rect_y = '0;
  logic signed [FIELD_W-1:0] rect_w = '0;
  logic signed [FIELD_W-1:0] rect_h = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [SLOT_W-1:0]         slot;
  logic [COORD_W-1:0]        region_x;
  logic [COORD_W-1:0]        region_y;
  logic [COORD_W-1:0]        region_w;
  logic [COORD_W-1:0]        region_h;
  logic [TOTAL_W-1:0]        region_total;
  logic                      last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0]     pwdata = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  int           clip_w = SCREEN_W_RESET;
  int           clip_h = SCREEN_H_RESET;
  area_t        dirty_box [NUM_SLOTS];
  int           dirty_count = 0;
  rect_item_t   pending_items [$];
  region_word_t words_due [$];
  rect_item_t   cur_item;
  int           items_queued = 0;
  int           items_taken = 0;
  int           words_seen = 0;
  int           mismatches = 0;
  int           cycles = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;
  bit           hold_go = 1'b0;
  bit           hold_done = 1'b0;

  dirty_region_merger uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic bit areas_touch(area_t a, area_t b);
    return !(a.x + a.w < b.x || b.x + b.w < a.x || a.y + a.h < b.y || b.y + b.h < a.y);
  endfunction

  function automatic area_t join_areas(area_t a, area_t b);
    area_t r;
    int    x2, y2;
    x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = x2 - r.x;
    r.h = y2 - r.y;
    return r;
  endfunction

  task automatic push_word(status_t st, int idx, area_t a, int total, bit fin);
    region_word_t w;
    w.st    = st;
    w.slot  = SLOT_W'(idx);
    w.rx    = COORD_W'(a.x);
    w.ry    = COORD_W'(a.y);
    w.rw    = COORD_W'(a.w);
    w.rh    = COORD_W'(a.h);
    w.total = TOTAL_W'(total);
    w.last  = fin;
    words_due.push_back(w);
  endtask

  task automatic track_item(rect_item_t it);
    area_t c, none;
    int    x2, y2, k;
    none = '{0, 0, 0, 0};
    if (it.op == OP_DRAIN) begin
      if (dirty_count == 0) push_word(ST_EMPTY, 0, none, 0, 1'b1);
      for (k = 0; k < dirty_count; k++)
        push_word(ST_DRAINED, k, dirty_box[k], 0, k == dirty_count - 1);
      dirty_count = 0;
      return;
    end
    c.x = (it.x < 0) ? 0 : int'(it.x);
    c.y = (it.y < 0) ? 0 : int'(it.y);
    x2 = int'(it.x) + int'(it.w);
    y2 = int'(it.y) + int'(it.h);
    if (x2 > clip_w) x2 = clip_w;
    if (y2 > clip_h) y2 = clip_h;
    if (it.w <= 0 || it.h <= 0 || c.x >= x2 || c.y >= y2) begin
      push_word(ST_REJECTED, 0, none, dirty_count, 1'b1);
      return;
    end
    c.w = x2 - c.x;
    c.h = y2 - c.y;
    for (k = 0; k < dirty_count; k++) begin
      if (areas_touch(dirty_box[k], c)) begin
        dirty_box[k] = join_areas(dirty_box[k], c);
        push_word(ST_MERGED, k, dirty_box[k], dirty_count, 1'b1);
        return;
      end
    end
    if (dirty_count < NUM_SLOTS) begin
      dirty_box[dirty_count] = c;
      dirty_count++;
      push_word(ST_APPENDED, dirty_count - 1, c, dirty_count, 1'b1);
    end else begin
      dirty_box[0] = join_areas(dirty_box[0], c);
      push_word(ST_FOLDED, 0, dirty_box[0], dirty_count, 1'b1);
    end
  endtask

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < PRINT_CAP)
      $display("tb: mismatch on %s at word %0d: got %0d, expected %0d",
               what, words_seen, got, want);
    mismatches++;
  endtask

  task automatic queue_item(opcode_t op, int x, int y, int w, int h);
    rect_item_t it;
    it.op = op;
    it.x  = FIELD_W'(x);
    it.y  = FIELD_W'(y);
    it.w  = FIELD_W'(w);
    it.h  = FIELD_W'(h);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random(int n);
    int j, r, sw, sh, x, y, w, h;
    sw = (clip_w > 0) ? clip_w : 1;
    sh = (clip_h > 0) ? clip_h : 1;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      x = $urandom_range(0, sw - 1);
      y = $urandom_range(0, sh - 1);
      w = $urandom_range(1, (sw + 7) / 8);
      h = $urandom_range(1, (sh + 7) / 8);
      if (r < 8) begin
        queue_item(OP_DRAIN, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 14) begin
        if ($urandom_range(0, 1)) w = -int'($urandom_range(0, 32768));
        else h = -int'($urandom_range(0, 32768));
        queue_item(OP_MARK, x, y, w, h);
      end else if (r < 22) begin
        queue_item(OP_MARK, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 32) begin
        x = int'($urandom_range(0, sw + 64)) - 32;
        y = int'($urandom_range(0, sh + 64)) - 32;
        queue_item(OP_MARK, x, y, $urandom_range(1, 64), $urandom_range(1, 64));
      end else if (r < 38) begin
        queue_item(OP_MARK, x, y, $urandom_range(1, 32767), $urandom_range(1, 32767));
      end else begin
        queue_item(OP_MARK, x, y, w, h);
      end
    end
  endtask

  task automatic apb_write(reg_idx_t idx, int val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) clip_w = val & 'h7FF;
    else clip_h = val & 'h7FF;
  endtask

  task automatic set_screen(int w, int h);
    apb_write(REG_SCREEN_WIDTH, w);
    apb_write(REG_SCREEN_HEIGHT, h);
  endtask

  task automatic wait_quiet();
    while (items_taken != items_queued || words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver: one word per handshake, payload held while stalled
  always @(posedge clk) begin
    bit taken;
    bit nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      nxt_valid = in_valid && !taken;
      if (taken) begin
        track_item(cur_item);
        items_taken++;
        send_gap = idle_on ? pick_gap() : 0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          opcode <= cur_item.op;
          rect_x <= cur_item.x;
          rect_y <= cur_item.y;
          rect_w <= cur_item.w;
          rect_h <= cur_item.h;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: compare each accepted word with the oldest one due
  always @(posedge clk) begin
    region_word_t want;
    bit nxt_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          flag_mismatch("word with nothing due", status, 0);
        end else begin
          want = words_due.pop_front();
          if (status !== want.st) flag_mismatch("status", status, want.st);
          if (slot !== want.slot) flag_mismatch("slot", slot, want.slot);
          if (region_x !== want.rx) flag_mismatch("region_x", region_x, want.rx);
          if (region_y !== want.ry) flag_mismatch("region_y", region_y, want.ry);
          if (region_w !== want.rw) flag_mismatch("region_w", region_w, want.rw);
          if (region_h !== want.rh) flag_mismatch("region_h", region_h, want.rh);
          if (region_total !== want.total)
            flag_mismatch("region_total", region_total, want.total);
          if (last !== want.last) flag_mismatch("last", last, want.last);
        end
        words_seen++;
      end
      if (hold_go && !hold_done) begin
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
        if (idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
      out_stall <= nxt_stall;
    end
  end

  initial begin
    wait (hold_go);
    repeat (LONG_HOLD) @(posedge clk);
    hold_done <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_item(OP_DRAIN, 0, 0, 0, 0);
    queue_item(OP_MARK, 10, 10, 0, 5);
    queue_item(OP_MARK, 10, 10, 5, -32768);
    queue_item(OP_MARK, -32768, -32768, 32767, 32767);
    queue_item(OP_MARK, 32767, 0, 1, 1);
    queue_item(OP_MARK, -10, -10, 20, 20);
    queue_item(OP_MARK, 10, 0, 5, 5);
    queue_item(OP_MARK, 100, 100, 10, 10);
    queue_item(OP_MARK, 200, 0, 5, 5);
    queue_item(OP_MARK, 0, 200, 5, 5);
    queue_item(OP_MARK, 200, 200, 5, 5);
    queue_item(OP_MARK, 150, 0, 5, 5);
    queue_item(OP_MARK, 0, 150, 5, 5);
    queue_item(OP_MARK, 60, 60, 5, 5);
    queue_item(OP_MARK, 230, 100, 5, 5);
    queue_item(OP_MARK, 32767, 32767, 32767, 32767);
    queue_item(OP_MARK, 0, 0, 32767, 32767);
    queue_item(OP_DRAIN, -1, -1, -1, -1);
    queue_item(OP_DRAIN, 0, 0, 0, 0);
    queue_item(OP_MARK, 239, 239, 1, 1);
    queue_item(OP_MARK, 240, 0, 5, 5);
    queue_item(OP_MARK, -5, 239, 32767, 1);
    queue_item(OP_DRAIN, 0, 0, 0, 0);
    wait_quiet();

    set_screen(2047, 2047);
    queue_random(100);
    wait_quiet();

    // hold the output side while the sender keeps offering
    idle_on <= 1'b0;
    hold_go <= 1'b1;
    queue_random(40);
    wait_quiet();
    idle_on <= 1'b1;

    set_screen(1, 1);
    queue_random(30);
    wait_quiet();

    set_screen(0, 2047);
    queue_random(15);
    wait_quiet();

    set_screen(2047, 0);
    queue_random(15);
    wait_quiet();

    for (k = 0; k < 4; k++) begin
      set_screen($urandom_range(1, 2047), $urandom_range(1, 2047));
      idle_on <= (k != 2);
      queue_random(50);
      wait_quiet();
    end

    if (words_due.size() != 0) flag_mismatch("words never seen", 0, words_due.size());
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
